>>> rtl/core/spi_ms_pkg.sv
// spi_ms_pkg: types and constants shared by the spi master shifter modules
// no dependencies
`default_nettype none

package spi_ms_pkg;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_W      = 16;
   localparam int WORD_W     = 16;
   localparam int TICK_W     = 15;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_CPOL      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CPHA      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LSB_FIRST = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DIVIDER   = 2'd3;

   localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'd2;

   // quarters of one bit period
   localparam logic [1:0] QTR_SETUP = 2'd0;
   localparam logic [1:0] QTR_DRIVE = 2'd1;
   localparam logic [1:0] QTR_LEAD  = 2'd2;
   localparam logic [1:0] QTR_TRAIL = 2'd3;

   typedef struct packed {
      logic             cpol;
      logic             cpha;
      logic             lsb_first;
      logic [DIV_W-1:0] clock_divider;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [WORD_W-1:0] tx_word;
      logic              wide;
      logic              miso_in;
   } tick_type;

   typedef struct packed {
      logic              active;
      logic              word_is_wide;
      logic [1:0]        quarter;
      logic [TICK_W-1:0] tick_count;
      logic              clock_level;
      logic              data_level;
   } ctl_type;

   typedef struct packed {
      logic              sclk;
      logic              mosi_out;
      logic              busy_res;
      logic              done_res;
      logic [WORD_W-1:0] rx_word;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/spi_ms_csr.sv
// spi_ms_csr: configuration registers of the spi master shifter
// depends on spi_ms_pkg
`default_nettype none

module spi_ms_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [spi_ms_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [spi_ms_pkg::CSR_DATA_W-1:0] csr_wdata,
   output spi_ms_pkg::cfg_type                   cfg
);
   import spi_ms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CPOL:      cfg_in.cpol          = csr_wdata[0];
            CSR_CPHA:      cfg_in.cpha          = csr_wdata[0];
            CSR_LSB_FIRST: cfg_in.lsb_first     = csr_wdata[0];
            CSR_DIVIDER:   cfg_in.clock_divider = csr_wdata[DIV_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cpol          <= 1'b0;
         cfg_ff.cpha          <= 1'b0;
         cfg_ff.lsb_first     <= 1'b0;
         cfg_ff.clock_divider <= DIVIDER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/spi_ms_step.sv
// spi_ms_step: next-state and result logic for one timer tick
// depends on spi_ms_pkg
`default_nettype none

module spi_ms_step #(
   parameter int MAX_WORD_BITS = 16,
   parameter int BIT_W         = 4
) (
   input  wire spi_ms_pkg::cfg_type      cfg,
   input  wire spi_ms_pkg::tick_type     tick,
   input  wire spi_ms_pkg::ctl_type      ctl_cur,
   input  wire logic [BIT_W-1:0]         bit_cur,
   input  wire logic [MAX_WORD_BITS-1:0] tx_cur,
   input  wire logic [MAX_WORD_BITS-1:0] rx_cur,
   output spi_ms_pkg::ctl_type           ctl_nxt,
   output logic [BIT_W-1:0]              bit_nxt,
   output logic [MAX_WORD_BITS-1:0]      tx_nxt,
   output logic [MAX_WORD_BITS-1:0]      rx_nxt,
   output spi_ms_pkg::result_type        res
);
   import spi_ms_pkg::*;

   localparam logic [BIT_W-1:0]         LAST_WIDE = BIT_W'(MAX_WORD_BITS - 1);
   localparam logic [BIT_W-1:0]         LAST_BYTE = BIT_W'(7);
   localparam logic [MAX_WORD_BITS-1:0] BYTE_MASK = MAX_WORD_BITS'(8'hff);

   logic [TICK_W-1:0]        phase_len;
   logic [TICK_W:0]          cnt_inc;
   logic                     expire;
   logic [BIT_W-1:0]         last_bit;
   logic [BIT_W-1:0]         drv_idx;
   logic                     drv_bit;
   logic [MAX_WORD_BITS-1:0] rx_lsb;
   logic [MAX_WORD_BITS-1:0] rx_msb;
   logic [MAX_WORD_BITS-1:0] rx_sampled;
   logic                     done;

   // quarter length is max(1, divider/2)
   assign phase_len = (cfg.clock_divider[DIV_W-1:1] == '0) ?
                      TICK_W'(1) : cfg.clock_divider[DIV_W-1:1];
   assign cnt_inc   = {1'b0, ctl_cur.tick_count} + (TICK_W+1)'(1);
   assign expire    = cnt_inc >= {1'b0, phase_len};

   assign last_bit  = ctl_cur.word_is_wide ? LAST_WIDE : LAST_BYTE;
   assign drv_idx   = cfg.lsb_first ? bit_cur : (last_bit - bit_cur);
   assign drv_bit   = tx_cur[drv_idx];

   always_comb begin
      rx_lsb           = rx_cur >> 1;
      rx_lsb[last_bit] = tick.miso_in;
      rx_msb           = {rx_cur[MAX_WORD_BITS-2:0], tick.miso_in};
      if (!ctl_cur.word_is_wide) begin
         rx_msb = rx_msb & BYTE_MASK;
      end
      rx_sampled = cfg.lsb_first ? rx_lsb : rx_msb;
   end

   always_comb begin
      ctl_nxt = ctl_cur;
      bit_nxt = bit_cur;
      tx_nxt  = tx_cur;
      rx_nxt  = rx_cur;
      done    = 1'b0;
      if (ctl_cur.active) begin
         if (expire) begin
            ctl_nxt.tick_count = '0;
            unique case (ctl_cur.quarter)
               QTR_SETUP: begin
                  ctl_nxt.quarter = QTR_DRIVE;
                  if (!cfg.cpha) begin
                     ctl_nxt.data_level = drv_bit;
                  end
               end
               QTR_DRIVE: begin
                  ctl_nxt.quarter     = QTR_LEAD;
                  ctl_nxt.clock_level = ~cfg.cpol;
                  if (cfg.cpha) begin
                     ctl_nxt.data_level = drv_bit;
                  end else begin
                     rx_nxt = rx_sampled;
                  end
               end
               QTR_LEAD: begin
                  ctl_nxt.quarter = QTR_TRAIL;
               end
               QTR_TRAIL: begin
                  // trailing edge closes the bit
                  ctl_nxt.quarter     = QTR_SETUP;
                  ctl_nxt.clock_level = cfg.cpol;
                  if (cfg.cpha) begin
                     rx_nxt = rx_sampled;
                  end
                  if (bit_cur == last_bit) begin
                     ctl_nxt.active = 1'b0;
                     done           = 1'b1;
                     bit_nxt        = '0;
                  end else begin
                     bit_nxt = bit_cur + BIT_W'(1);
                  end
               end
            endcase
         end else begin
            ctl_nxt.tick_count = cnt_inc[TICK_W-1:0];
         end
      end else begin
         ctl_nxt.clock_level = cfg.cpol;
         if (tick.cmd) begin
            ctl_nxt.word_is_wide = tick.wide;
            ctl_nxt.active       = 1'b1;
            ctl_nxt.quarter      = QTR_SETUP;
            ctl_nxt.tick_count   = '0;
            bit_nxt              = '0;
            rx_nxt               = '0;
            tx_nxt = tick.wide ? MAX_WORD_BITS'(tick.tx_word)
                               : MAX_WORD_BITS'(tick.tx_word[7:0]);
         end
      end
   end

   always_comb begin
      res.sclk     = ctl_nxt.clock_level;
      res.mosi_out = ctl_nxt.data_level;
      res.busy_res = ctl_nxt.active;
      res.done_res = done;
      res.rx_word  = done ? WORD_W'(rx_nxt) : '0;
   end

endmodule

`default_nettype wire

>>> rtl/core/spi_master_shifter_unit.sv
// spi_master_shifter_unit: spi master shifter advanced one timer tick per transaction
// depends on spi_ms_pkg, spi_ms_csr and spi_ms_step
// Each request transaction is one tick of the bit timer and gives exactly one
// response transaction carrying the serial line levels, busy, done and the received
// word. A tick passes through one layer of next-state logic into the shifter state
// and the result register, so the unit takes one tick per clock cycle whenever the
// response side is ready; a response is valid in the cycle after its tick is
// accepted. The result register lets a new tick in while the previous response
// is being taken. Each bit lasts four quarters of max(1, clock_divider/2) ticks;
// a start on a tick with tuser set is ignored while a transfer is running. The user
// must write configuration only while no tick is outstanding; this is not enforced.
`default_nettype none

module spi_master_shifter_unit #(
   parameter int MAX_WORD_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // tdata: tx_word[15:0], wide[16], miso_in[17], zero pad
   input  wire logic [spi_ms_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[0]
   input  wire logic [0:0]                       req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: sclk[0], mosi_out[1], busy_res[2], done_res[3], rx_word[19:4], zero pad
   output logic [spi_ms_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_we,
   input  wire logic [spi_ms_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [spi_ms_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spi_ms_pkg::*;

   localparam int BIT_W = $clog2(MAX_WORD_BITS);

   cfg_type                  cfg;
   tick_type                 tick;
   ctl_type                  ctl_ff, ctl_in;
   logic [BIT_W-1:0]         bit_ff, bit_in;
   logic [MAX_WORD_BITS-1:0] tx_ff, tx_in;
   logic [MAX_WORD_BITS-1:0] rx_ff, rx_in;
   result_type               res;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic                     rsp_valid_ff;
   logic                     accept;

   spi_ms_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign tick.cmd     = req_tuser[0];
   assign tick.tx_word = req_tdata[WORD_W-1:0];
   assign tick.wide    = req_tdata[WORD_W];
   assign tick.miso_in = req_tdata[WORD_W+1];

   spi_ms_step #(
      .MAX_WORD_BITS (MAX_WORD_BITS),
      .BIT_W         (BIT_W)
   ) u_step (
      .cfg     (cfg),
      .tick    (tick),
      .ctl_cur (ctl_ff),
      .bit_cur (bit_ff),
      .tx_cur  (tx_ff),
      .rx_cur  (rx_ff),
      .ctl_nxt (ctl_in),
      .bit_nxt (bit_in),
      .tx_nxt  (tx_in),
      .rx_nxt  (rx_in),
      .res     (res)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         bit_ff <= '0;
         tx_ff  <= '0;
         rx_ff  <= '0;
      end else if (accept) begin
         ctl_ff <= ctl_in;
         bit_ff <= bit_in;
         tx_ff  <= tx_in;
         rx_ff  <= rx_in;
      end else if (csr_we && (csr_addr == CSR_CPOL) && !ctl_ff.active) begin
         // idle clock level follows a new polarity at once
         ctl_ff.clock_level <= csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= {(RSP_DATA_W - WORD_W - 4)'(0), res.rx_word, res.done_res,
                         res.busy_res, res.mosi_out, res.sclk};
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
